// ===== rtl/core/qtm_pkg.sv =====
// Package for the query text minifier: character constants, byte class
// functions and the result record type. No dependencies.
package qtm_pkg;

    // Characters with a special meaning in the byte stream
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Result queue geometry
    localparam int QTM_FIFO_DEPTH = 4;
    localparam int QTM_PTR_W      = $clog2(QTM_FIFO_DEPTH);

    // One result item as stored in the output queue
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_output;
        logic       last_of_run;
    } qtm_result_t;

    // Whitespace: HT, LF, VT, FF, CR and space
    function automatic logic qtm_is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    // Punctuators: ! $ ( ) , . : = @ [ ] { | }
    function automatic logic qtm_is_punct(input logic [7:0] b);
        logic res;
        unique case (b)
            8'h21, 8'h24, 8'h28, 8'h29, 8'h2C, 8'h2E, 8'h3A,
            8'h3D, 8'h40, 8'h5B, 8'h5D, 8'h7B, 8'h7C, 8'h7D: res = 1'b1;
            default:                                          res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/query_text_minifier.sv =====
// Query text minifier top level: input register, one-pass minify logic and
// a small result queue. Depends on qtm_pkg.
//
// The block takes one query byte per item and strips comments and redundant
// whitespace, holding back the latest output byte until a later byte or the
// end of the query releases it. Each input item is registered, processed by
// the minify logic, and its 0, 1 or 2 result items are written into a
// four-entry result queue; one result item leaves per cycle while the
// receiver does not stall. An input item can be taken every cycle as long as
// the queue holds at most two results, so the sustained rate is one item per
// cycle, limited by receiver stalls and by the single output port when an
// item produces two results (end of query with a released byte). The first
// result item of an input item shows on the outputs after the input register
// and the queue write; a queue short of room holds the item in the input
// register. No configuration and no clearing pass after reset.
module query_text_minifier
    import qtm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // text byte channel
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       query_end,
    // result channel
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       end_of_output,
    output logic       last_of_run
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // Minifier state
    logic [7:0] held_byte_reg,  held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       in_comment_reg, in_comment_next;

    // Result queue
    qtm_result_t                fifo_reg [QTM_FIFO_DEPTH];
    logic [QTM_PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QTM_PTR_W:0]         count_reg,  count_next;

    logic        fire;
    logic        pop;
    logic        text_take;
    logic        feed;
    logic [7:0]  fed;
    logic        comment_after;
    logic        offer_en;
    logic [7:0]  oc;
    logic        oc_ws;
    logic        rel;
    logic [7:0]  rel_byte;
    logic [7:0]  hb_off;
    logic        hv_off;
    logic [1:0]  n_wr;
    qtm_result_t res0, res1;

    // Handshake: stage advances when the queue has room for two results
    assign fire       = in_valid_reg &&
                        (count_reg <= (QTM_PTR_W+1)'(QTM_FIFO_DEPTH - 2));
    assign text_stall = in_valid_reg && !fire;
    assign text_take  = text_valid && !text_stall;
    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;

    // Comment tracking and byte normalization
    always_comb
    begin
        feed          = 1'b0;
        fed           = in_byte_reg;
        comment_after = in_comment_reg;
        if (in_comment_reg)
        begin
            if (in_byte_reg == CH_LF)
            begin
                comment_after = 1'b0;
                feed          = 1'b1;
                fed           = CH_LF;
            end
        end
        else if (in_byte_reg == CH_HASH)
        begin
            comment_after = 1'b1;
        end
        else
        begin
            feed = 1'b1;
            fed  = (in_byte_reg == CH_CR) ? CH_LF : in_byte_reg;
        end
        // an open comment at query end stands for one LF
        offer_en = feed || (in_end_reg && comment_after);
        oc       = feed ? fed : CH_LF;
    end

    // Offer the byte to the held-byte compressor
    always_comb
    begin
        oc_ws    = qtm_is_ws(oc);
        rel      = 1'b0;
        rel_byte = held_byte_reg;
        hb_off   = held_byte_reg;
        hv_off   = held_valid_reg;
        if (offer_en)
        begin
            if (!held_valid_reg)
            begin
                if (!oc_ws)
                begin
                    hb_off = oc;
                    hv_off = 1'b1;
                end
            end
            else if (qtm_is_ws(held_byte_reg))
            begin
                if (oc_ws)
                begin
                    if (oc == CH_LF)
                        hb_off = oc;
                end
                else if (qtm_is_punct(oc))
                begin
                    hb_off = oc;
                end
                else
                begin
                    rel    = 1'b1;
                    hb_off = oc;
                end
            end
            else if (!oc_ws || !qtm_is_punct(held_byte_reg))
            begin
                rel    = 1'b1;
                hb_off = oc;
            end
        end
    end

    // Build result items and next state
    always_comb
    begin
        res1.out_byte      = hv_off ? hb_off : 8'h00;
        res1.has_byte      = hv_off;
        res1.end_of_output = 1'b1;
        res1.last_of_run   = 1'b1;

        if (rel)
        begin
            res0.out_byte      = rel_byte;
            res0.has_byte      = 1'b1;
            res0.end_of_output = 1'b0;
            res0.last_of_run   = !in_end_reg;
        end
        else
        begin
            res0 = res1;
        end

        n_wr = 2'(rel) + 2'(in_end_reg);

        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        in_comment_next = in_comment_reg;
        if (fire)
        begin
            if (in_end_reg)
            begin
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
                in_comment_next = 1'b0;
            end
            else
            begin
                held_byte_next  = hb_off;
                held_valid_next = hv_off;
                in_comment_next = comment_after;
            end
        end

        count_next = count_reg - (QTM_PTR_W+1)'(pop)
                   + (fire ? (QTM_PTR_W+1)'(n_wr) : '0);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            in_comment_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (text_take)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            in_comment_reg <= in_comment_next;
            if (fire)
                wr_ptr_reg <= wr_ptr_reg + QTM_PTR_W'(n_wr);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Payload registers: input item and queue storage
    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            in_byte_reg <= text_byte;
            in_end_reg  <= query_end;
        end
        if (fire && (n_wr != 2'd0))
            fifo_reg[wr_ptr_reg] <= res0;
        if (fire && (n_wr == 2'd2))
            fifo_reg[wr_ptr_reg + 1'b1] <= res1;
    end

    // Queue head drives the result ports
    assign out_byte      = fifo_reg[rd_ptr_reg].out_byte;
    assign has_byte      = fifo_reg[rd_ptr_reg].has_byte;
    assign end_of_output = fifo_reg[rd_ptr_reg].end_of_output;
    assign last_of_run   = fifo_reg[rd_ptr_reg].last_of_run;

`ifndef SYNTHESIS
    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QTM_PTR_W+1)'(QTM_FIFO_DEPTH))
        else $error("result queue overflow");

    // end of query returns the minifier to its initial state
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_end_reg) |=> (!held_valid_reg && !in_comment_reg))
        else $error("state not cleared after query end");

    // final result of a query always closes its run
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && end_of_output) |-> last_of_run)
        else $error("end of output without last of run");

    // a pending input item is only held back when the queue is short of room
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> (count_reg > (QTM_PTR_W+1)'(QTM_FIFO_DEPTH - 2)))
        else $error("input stalled with queue room available");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for query_text_minifier: streams query bytes under
// several idle and stall mixes and checks every result item against a local
// minifier model. Depends on qtm_pkg and the query_text_minifier RTL.
module tb_top
    import qtm_pkg::*;
();

    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    DRAIN_CYCLES = 20;
    localparam int    HOLD_CYCLES  = 250;
    localparam string PUNCTUATORS  = "!$(),.:=@[]{|}";
    localparam string NAME_CHARS   =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       text_valid   = 1'b0;
    logic       text_stall;
    logic [7:0] text_byte    = 8'h00;
    logic       query_end    = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_output;
    logic       last_of_run;

    // Minifier model state
    logic [7:0] mdl_held_byte  = 8'h00;
    logic       mdl_held_valid = 1'b0;
    logic       mdl_in_comment = 1'b0;

    // Result items predicted but not yet seen on the output
    qtm_result_t due_results[$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int error_count     = 0;
    int bytes_sent      = 0;
    int queries_sent    = 0;
    int results_checked = 0;

    query_text_minifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_byte     (text_byte),
        .query_end     (query_end),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_byte      (out_byte),
        .has_byte      (has_byte),
        .end_of_output (end_of_output),
        .last_of_run   (last_of_run)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d result items still due", $time,
                     due_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic bit is_punctuator(input logic [7:0] b);
        for (int i = 0; i < PUNCTUATORS.len(); i++)
        begin
            if (PUNCTUATORS[i] == b)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one byte to the blank compressor; 1 when the held byte is pushed out
    function automatic bit compress_byte(input logic [7:0] c, output logic [7:0] released);
        bit c_blank;
        c_blank  = is_blank(c);
        released = 8'h00;
        // leading blanks are dropped
        if (!mdl_held_valid)
        begin
            if (!c_blank)
            begin
                mdl_held_byte  = c;
                mdl_held_valid = 1'b1;
            end
            return 1'b0;
        end
        // held blank: merge with blanks (LF wins), give way to a punctuator
        if (is_blank(mdl_held_byte))
        begin
            if (c_blank)
            begin
                if (c == CH_LF)
                    mdl_held_byte = c;
                return 1'b0;
            end
            if (is_punctuator(c))
            begin
                mdl_held_byte = c;
                return 1'b0;
            end
            released      = mdl_held_byte;
            mdl_held_byte = c;
            return 1'b1;
        end
        // held non-blank: a blank after a punctuator is dropped
        if (!c_blank || !is_punctuator(mdl_held_byte))
        begin
            released      = mdl_held_byte;
            mdl_held_byte = c;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the result items caused by one accepted input item
    task automatic predict_minified(input logic [7:0] c, input logic last);
        logic [7:0]  fed;
        logic [7:0]  rel_fed;
        logic [7:0]  rel_close;
        logic [7:0]  rel;
        bit          feed;
        bit          got_rel;
        qtm_result_t one_result;
        qtm_result_t step_results[$];
        feed    = 1'b0;
        fed     = c;
        got_rel = 1'b0;
        rel     = 8'h00;
        // comment tracking; CR outside a comment reads as LF
        if (mdl_in_comment)
        begin
            if (c == CH_LF)
            begin
                mdl_in_comment = 1'b0;
                feed           = 1'b1;
            end
        end
        else if (c == CH_HASH)
            mdl_in_comment = 1'b1;
        else
        begin
            feed = 1'b1;
            if (c == CH_CR)
                fed = CH_LF;
        end
        if (feed && compress_byte(fed, rel_fed))
        begin
            got_rel = 1'b1;
            rel     = rel_fed;
        end
        // comment still open at the query end closes as one LF
        if (last && mdl_in_comment)
        begin
            mdl_in_comment = 1'b0;
            if (compress_byte(CH_LF, rel_close))
            begin
                got_rel = 1'b1;
                rel     = rel_close;
            end
        end
        if (got_rel)
        begin
            one_result.out_byte      = rel;
            one_result.has_byte      = 1'b1;
            one_result.end_of_output = 1'b0;
            one_result.last_of_run   = 1'b0;
            step_results = {step_results, one_result};
        end
        // flush: held byte or empty end marker
        if (last)
        begin
            one_result.out_byte      = mdl_held_valid ? mdl_held_byte : 8'h00;
            one_result.has_byte      = mdl_held_valid;
            one_result.end_of_output = 1'b1;
            one_result.last_of_run   = 1'b0;
            step_results = {step_results, one_result};
            mdl_held_byte  = 8'h00;
            mdl_held_valid = 1'b0;
            mdl_in_comment = 1'b0;
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        due_results = {due_results, step_results};
    endtask

    // Offer one item and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        query_end  <= last;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        predict_minified(b, last);
        bytes_sent++;
        if (last)
            queries_sent++;
    endtask

    task automatic send_text(input string s, input bit end_at_last);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], end_at_last && (i == s.len() - 1));
    endtask

    // Receiver: long hold-off when requested, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each accepted result item with the oldest one due
    always @(posedge clk)
    begin : result_check
        qtm_result_t got;
        qtm_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{out_byte: out_byte, has_byte: has_byte,
                    end_of_output: end_of_output, last_of_run: last_of_run};
            if (due_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected item: byte=%02h has=%b end=%b last=%b",
                         $time, got.out_byte, got.has_byte, got.end_of_output,
                         got.last_of_run);
            end
            else
            begin
                want = due_results.pop_front();
                results_checked++;
                if (got !== want)
                begin
                    error_count++;
                    $display({"%0t: mismatch: expected byte=%02h has=%b end=%b last=%b,",
                              " got byte=%02h has=%b end=%b last=%b"},
                             $time, want.out_byte, want.has_byte, want.end_of_output,
                             want.last_of_run, got.out_byte, got.has_byte,
                             got.end_of_output, got.last_of_run);
                end
            end
        end
    end

    // Hand-picked queries: blanks, punctuators, CR, comments, flush corners
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // blanks around punctuators, CR as LF, comment holding CR and hash
        send_text("  a ,\tb\015#c#\015d\n x", 1'b1);
        // lone blank query gives the empty end marker
        send_text(" ", 1'b1);
        // comment open at the query end
        send_text("z#q", 1'b1);
        // NUL and all-ones bytes, then a trailing blank flushed as it is
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_TAB, 1'b1);
    endtask

    // Query-like byte streams with some raw noise
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        logic [7:0] query_bytes[$];
        logic [7:0] nb;
        int         target;
        int         run_len;
        int         kind;
        int         pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = bytes_sent + n_items;
        while (bytes_sent < target)
        begin
            query_bytes.delete();
            run_len = ($urandom_range(19) == 0) ? 1 : $urandom_range(40, 1);
            while (query_bytes.size() < run_len)
            begin
                kind = $urandom_range(99);
                if (kind < 30)
                begin
                    repeat ($urandom_range(6, 1))
                    begin
                        nb = NAME_CHARS[$urandom_range(NAME_CHARS.len() - 1)];
                        query_bytes = {query_bytes, nb};
                    end
                end
                else if (kind < 50)
                begin
                    nb = PUNCTUATORS[$urandom_range(PUNCTUATORS.len() - 1)];
                    query_bytes = {query_bytes, nb};
                end
                else if (kind < 70)
                begin
                    repeat ($urandom_range(4, 1))
                    begin
                        pick = $urandom_range(5);
                        nb   = (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
                        query_bytes = {query_bytes, nb};
                    end
                end
                else if (kind < 78)
                begin
                    // comment body may hold CR and hash; usually closed by LF
                    nb = CH_HASH;
                    query_bytes = {query_bytes, nb};
                    repeat ($urandom_range(8))
                    begin
                        pick = $urandom_range(9);
                        if (pick == 0)
                            nb = CH_CR;
                        else if (pick == 1)
                            nb = CH_HASH;
                        else
                            nb = 8'($urandom_range(8'h7E, 8'h20));
                        query_bytes = {query_bytes, nb};
                    end
                    if ($urandom_range(9) < 8)
                    begin
                        nb = CH_LF;
                        query_bytes = {query_bytes, nb};
                    end
                end
                else if (kind < 88)
                begin
                    nb = 8'($urandom_range(8'h7E, 8'h21));
                    query_bytes = {query_bytes, nb};
                end
                else
                begin
                    nb = 8'($urandom_range(255));
                    query_bytes = {query_bytes, nb};
                end
            end
            foreach (query_bytes[i])
                send_item(query_bytes[i], i == query_bytes.size() - 1);
        end
    endtask

    // Receiver holds off while the sender keeps offering, filling the block
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_item(NAME_CHARS[$urandom_range(NAME_CHARS.len() - 1)], i == 39);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(0, 0, 360);
        test_random_traffic(74, 0, 360);
        test_random_traffic(0, 74, 360);
        test_random_traffic(11, 11, 360);
        test_backpressure();
        text_valid <= 1'b0;
        // drain what is still due, then idle before reporting
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d queries, %0d bytes in, %0d result items checked",
                 queries_sent, bytes_sent, results_checked);
        $display("under four idle/stall mixes and a %0d-cycle output hold-off; %0d errors",
                 HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
